// File: hdl/mesh_vertex_normals_core_macros.svh
// Assertion macros used by the top-level design file.
`ifndef MESH_VERTEX_NORMALS_CORE_MACROS_SVH
`define MESH_VERTEX_NORMALS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define MVN_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mesh_vertex_normals_core: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define MVN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mesh_vertex_normals_core: assertion failed");
`else
`define MVN_ASSERT_SAME(label, clk, rst, ante, cons)
`define MVN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/mvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mvn_pkg;

  // Field and store widths.
  localparam int VIDX_W     = 10;
  localparam int VERT_DEPTH = 1024;
  localparam int COORD_W    = 32;
  localparam int NORM_W     = 18;
  localparam int SUM_W      = 26;
  localparam int VERT_W     = 3 * COORD_W;
  localparam int SUMS_W     = 3 * SUM_W;
  localparam int KIND_W     = 2;

  // Datapath widths.
  localparam int EDGE_W  = COORD_W + 1;
  localparam int ESH_W   = 31;
  localparam int PROD_W  = 2 * ESH_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIV_W   = MAG_W + 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRI   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  // One queued item.
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [VIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [VIDX_W-1:0]         ca;
    logic [VIDX_W-1:0]         cb;
    logic [VIDX_W-1:0]         cc;
  } item_t;

  // Status of the normalisation unit.
  typedef struct packed {
    logic done;
    logic zero;
  } norm_status_t;

endpackage
`default_nettype wire

// File: hdl/mvn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/mvn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mvn_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [mvn_pkg::KIND_W-1:0]          kind,
  input  logic [mvn_pkg::VIDX_W-1:0]          vertex_index,
  input  logic signed [mvn_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [mvn_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [mvn_pkg::COORD_W-1:0]  pos_z,
  input  logic [mvn_pkg::VIDX_W-1:0]          corner_a,
  input  logic [mvn_pkg::VIDX_W-1:0]          corner_b,
  input  logic [mvn_pkg::VIDX_W-1:0]          corner_c,
  output logic                                busy,
  output mvn_pkg::item_t                      item,
  output logic                                item_valid,
  input  logic                                item_pop
);

  mvn_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           push;
  logic           pop;

  // A transaction is taken while the queue has room; reserved kinds are dropped here.
  assign accept     = start && !busy;
  assign push       = accept && (kind != mvn_pkg::KIND_RSVD);
  assign pop        = item_pop && item_valid;
  assign busy       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind, idx: vertex_index, px: pos_x, py: pos_y, pz: pos_z,
                         ca: corner_a, cb: corner_b, cc: corner_c};
    end
  end

endmodule
`default_nettype wire

// File: hdl/mvn_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module mvn_norm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [mvn_pkg::MAG_W-1:0]   vx,
  input  logic signed [mvn_pkg::MAG_W-1:0]   vy,
  input  logic signed [mvn_pkg::MAG_W-1:0]   vz,
  output mvn_pkg::norm_status_t              status,
  output logic signed [mvn_pkg::NORM_W-1:0]  nx,
  output logic signed [mvn_pkg::NORM_W-1:0]  ny,
  output logic signed [mvn_pkg::NORM_W-1:0]  nz
);

  typedef enum logic [5:0] {
    N_IDLE = 6'b000001,
    N_SQ   = 6'b000010,
    N_ROOT = 6'b000100,
    N_LOAD = 6'b001000,
    N_DIV  = 6'b010000,
    N_OUT  = 6'b100000
  } nstate_t;

  nstate_t                            state;
  logic [mvn_pkg::MAG_W-1:0]          mag [3];
  logic [2:0]                         neg;
  logic [mvn_pkg::SQ_W-1:0]           sq;
  logic [mvn_pkg::SQ_W-1:0]           acc;
  logic [mvn_pkg::SQ_W-1:0]           x;
  logic [mvn_pkg::SQ_W-1:0]           r;
  logic [mvn_pkg::SQ_W-1:0]           bitv;
  logic [mvn_pkg::MAG_W-1:0]          len;
  logic [mvn_pkg::DIV_W-1:0]          num;
  logic [mvn_pkg::MAG_W-1:0]          rem;
  logic [5:0]                         cnt;
  logic [1:0]                         comp;
  logic                               zero;
  logic signed [mvn_pkg::NORM_W-1:0]  res [3];

  logic [mvn_pkg::MAG_W-1:0]          sq_sel;
  logic [mvn_pkg::MAG_W-1:0]          div_sel;
  logic [mvn_pkg::SQ_W-1:0]           sq_w;
  logic [mvn_pkg::SQ_W-1:0]           trial;
  logic [mvn_pkg::SQ_W-1:0]           r_next;
  logic [mvn_pkg::MAG_W:0]            rem_sh;
  logic                               qbit;
  logic [mvn_pkg::DIV_W-1:0]          num_next;
  logic signed [mvn_pkg::NORM_W-1:0]  q18;

  // Operand selection for the squarer and the divider.
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    sq_sel = mag[0];
      2'd1:    sq_sel = mag[1];
      default: sq_sel = mag[2];
    endcase
    unique case (comp)
      2'd0:    div_sel = mag[0];
      2'd1:    div_sel = mag[1];
      default: div_sel = mag[2];
    endcase
  end

  // One square, one root step and one divide step per cycle.
  assign sq_w     = sq_sel * sq_sel;
  assign trial    = r + bitv;
  assign r_next   = (x >= trial) ? ((r >> 1) + bitv) : (r >> 1);
  assign rem_sh   = {rem, num[mvn_pkg::DIV_W-1]};
  assign qbit     = (rem_sh >= {1'b0, len});
  assign num_next = {num[mvn_pkg::DIV_W-2:0], qbit};
  assign q18      = $signed({1'b0, num_next[mvn_pkg::NORM_W-2:0]});

  assign status = '{done: (state == N_OUT), zero: zero};
  assign nx     = res[0];
  assign ny     = res[1];
  assign nz     = res[2];

  // Sequencer: sum of squares, integer square root, then three divisions unless the root is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt == 6'd3) begin
            state <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (bitv[0]) begin
            state <= (r_next == '0) ? N_OUT : N_LOAD;
          end
        end
        N_LOAD: begin
          state <= N_DIV;
        end
        N_DIV: begin
          if (cnt == 6'(mvn_pkg::DIV_W - 1)) begin
            state <= (comp == 2'd2) ? N_OUT : N_LOAD;
          end
        end
        N_OUT: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        mag[0] <= vx[mvn_pkg::MAG_W-1] ? (~vx + 1'b1) : vx;
        mag[1] <= vy[mvn_pkg::MAG_W-1] ? (~vy + 1'b1) : vy;
        mag[2] <= vz[mvn_pkg::MAG_W-1] ? (~vz + 1'b1) : vz;
        neg    <= {vz[mvn_pkg::MAG_W-1], vy[mvn_pkg::MAG_W-1], vx[mvn_pkg::MAG_W-1]};
        acc    <= '0;
        cnt    <= '0;
      end
      N_SQ: begin
        sq <= sq_w;
        if (cnt != 6'd0) begin
          acc <= acc + sq;
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd3) begin
          x    <= acc + sq;
          r    <= '0;
          bitv <= {2'b01, {(mvn_pkg::SQ_W - 2){1'b0}}};
        end
      end
      N_ROOT: begin
        if (x >= trial) begin
          x <= x - trial;
        end
        r    <= r_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          len  <= r_next[mvn_pkg::MAG_W-1:0];
          zero <= (r_next == '0);
          comp <= 2'd0;
          if (r_next == '0) begin
            res[0] <= '0;
            res[1] <= '0;
            res[2] <= '0;
          end
        end
      end
      N_LOAD: begin
        num <= {div_sel, 16'd0} + mvn_pkg::DIV_W'(len >> 1);
        rem <= '0;
        cnt <= '0;
      end
      N_DIV: begin
        rem <= qbit ? mvn_pkg::MAG_W'(rem_sh - {1'b0, len}) : mvn_pkg::MAG_W'(rem_sh);
        num <= num_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(mvn_pkg::DIV_W - 1)) begin
          res[comp] <= neg[comp] ? -q18 : q18;
          comp      <= comp + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/mvn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mvn_back (
  input  logic                               clk,
  input  logic                               rst,
  input  mvn_pkg::item_t                     item,
  input  logic                               item_valid,
  output logic                               item_pop,
  output logic                               norm_valid,
  output logic signed [mvn_pkg::NORM_W-1:0]  norm_x,
  output logic signed [mvn_pkg::NORM_W-1:0]  norm_y,
  output logic signed [mvn_pkg::NORM_W-1:0]  norm_z
);

  typedef enum logic [15:0] {
    B_IDLE   = 16'h0001,
    B_STORE  = 16'h0002,
    B_QRD    = 16'h0004,
    B_QNORM  = 16'h0008,
    B_QWAIT  = 16'h0010,
    B_TRD    = 16'h0020,
    B_EDGE   = 16'h0040,
    B_EMAG   = 16'h0080,
    B_ESHIFT = 16'h0100,
    B_CROSS  = 16'h0200,
    B_CMAG   = 16'h0400,
    B_CSHIFT = 16'h0800,
    B_TNORM  = 16'h1000,
    B_TWAIT  = 16'h2000,
    B_ARD    = 16'h4000,
    B_AWR    = 16'h8000
  } bstate_t;

  bstate_t                               state;
  mvn_pkg::item_t                        cur;
  logic [2:0]                            cnt;
  logic [1:0]                            acnt;
  logic [mvn_pkg::VERT_W-1:0]            vtx [3];
  logic signed [mvn_pkg::EDGE_W-1:0]     e [6];
  logic [mvn_pkg::EDGE_W-1:0]            emor;
  logic signed [mvn_pkg::ESH_W-1:0]      es [6];
  logic signed [mvn_pkg::PROD_W-1:0]     prod;
  logic signed [mvn_pkg::CROSS_W-1:0]    c [3];
  logic [mvn_pkg::CROSS_W-1:0]           cmor;
  logic signed [mvn_pkg::NORM_W-1:0]     face [3];

  // Memory and unit connections.
  logic                                  v_we;
  logic                                  v_re;
  logic [mvn_pkg::VIDX_W-1:0]            v_raddr;
  logic [mvn_pkg::VERT_W-1:0]            v_rdata;
  logic                                  s_we;
  logic [mvn_pkg::VIDX_W-1:0]            s_waddr;
  logic [mvn_pkg::SUMS_W-1:0]            s_wdata;
  logic                                  s_re;
  logic [mvn_pkg::VIDX_W-1:0]            s_raddr;
  logic [mvn_pkg::SUMS_W-1:0]            s_rdata;
  logic                                  n_start;
  logic signed [mvn_pkg::MAG_W-1:0]      n_in [3];
  mvn_pkg::norm_status_t                 n_status;
  logic signed [mvn_pkg::NORM_W-1:0]     n_out [3];

  logic [mvn_pkg::VIDX_W-1:0]            rd_corner;
  logic [mvn_pkg::VIDX_W-1:0]            acc_corner;
  logic signed [mvn_pkg::ESH_W-1:0]      op_a;
  logic signed [mvn_pkg::ESH_W-1:0]      op_b;
  logic [1:0]                            eshift;

  // Magnitude of a signed edge, unsigned, same width.
  function automatic logic [mvn_pkg::EDGE_W-1:0] emag(input logic signed [mvn_pkg::EDGE_W-1:0] v);
    emag = v[mvn_pkg::EDGE_W-1] ? mvn_pkg::EDGE_W'(-v) : mvn_pkg::EDGE_W'(v);
  endfunction

  // Magnitude of a signed cross product component.
  function automatic logic [mvn_pkg::CROSS_W-1:0] cmag(
      input logic signed [mvn_pkg::CROSS_W-1:0] v);
    cmag = v[mvn_pkg::CROSS_W-1] ? mvn_pkg::CROSS_W'(-v) : mvn_pkg::CROSS_W'(v);
  endfunction

  // Saturating add of one unit normal component to one sum component.
  function automatic logic [mvn_pkg::SUM_W-1:0] sat_add(input logic [mvn_pkg::SUM_W-1:0] s,
                                                        input logic signed [mvn_pkg::NORM_W-1:0] n);
    logic signed [mvn_pkg::SUM_W:0] t;
    t = $signed({s[mvn_pkg::SUM_W-1], s}) + (mvn_pkg::SUM_W + 1)'(n);
    if (t[mvn_pkg::SUM_W] != t[mvn_pkg::SUM_W-1]) begin
      sat_add = t[mvn_pkg::SUM_W] ? {1'b1, {(mvn_pkg::SUM_W - 1){1'b0}}}
                                  : {1'b0, {(mvn_pkg::SUM_W - 1){1'b1}}};
    end else begin
      sat_add = t[mvn_pkg::SUM_W-1:0];
    end
  endfunction

  mvn_ram #(.WIDTH(mvn_pkg::VERT_W), .DEPTH(mvn_pkg::VERT_DEPTH)) u_vertex_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (cur.idx),
    .wdata ({cur.px, cur.py, cur.pz}),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  mvn_ram #(.WIDTH(mvn_pkg::SUMS_W), .DEPTH(mvn_pkg::VERT_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mvn_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (n_start),
    .vx     (n_in[0]),
    .vy     (n_in[1]),
    .vz     (n_in[2]),
    .status (n_status),
    .nx     (n_out[0]),
    .ny     (n_out[1]),
    .nz     (n_out[2])
  );

  // Corner selection for vertex reads and sum updates.
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    rd_corner = cur.ca;
      2'd1:    rd_corner = cur.cb;
      default: rd_corner = cur.cc;
    endcase
    unique case (acnt)
      2'd0:    acc_corner = cur.ca;
      2'd1:    acc_corner = cur.cb;
      default: acc_corner = cur.cc;
    endcase
  end

  // Cross product operand pairs, one product per cycle.
  always_comb begin
    unique case (cnt)
      3'd0:    begin op_a = es[1]; op_b = es[5]; end
      3'd1:    begin op_a = es[2]; op_b = es[4]; end
      3'd2:    begin op_a = es[2]; op_b = es[3]; end
      3'd3:    begin op_a = es[0]; op_b = es[5]; end
      3'd4:    begin op_a = es[0]; op_b = es[4]; end
      default: begin op_a = es[1]; op_b = es[3]; end
    endcase
  end

  // Edge block shift brings every edge below 2^30 in magnitude.
  assign eshift = emor[32] ? 2'd3 : (emor[31] ? 2'd2 : (emor[30] ? 2'd1 : 2'd0));

  // Memory port and unit strobes.
  assign item_pop = (state == B_IDLE) && item_valid;
  assign v_we     = (state == B_STORE);
  assign v_re     = (state == B_TRD) && (cnt != 3'd3);
  assign v_raddr  = rd_corner;
  assign s_re     = (state == B_QRD) || (state == B_ARD);
  assign s_raddr  = (state == B_QRD) ? cur.idx : acc_corner;
  assign s_we     = (state == B_STORE) || (state == B_AWR);
  assign s_waddr  = (state == B_STORE) ? cur.idx : acc_corner;
  assign s_wdata  = (state == B_STORE) ? '0 :
                    {sat_add(s_rdata[77:52], face[0]), sat_add(s_rdata[51:26], face[1]),
                     sat_add(s_rdata[25:0], face[2])};
  assign n_start  = (state == B_QNORM) || (state == B_TNORM);

  // Normaliser input: a stored sum for a query, the reduced cross product for a triangle.
  always_comb begin
    if (state == B_QNORM) begin
      n_in[0] = mvn_pkg::MAG_W'($signed(s_rdata[77:52]));
      n_in[1] = mvn_pkg::MAG_W'($signed(s_rdata[51:26]));
      n_in[2] = mvn_pkg::MAG_W'($signed(s_rdata[25:0]));
    end else begin
      n_in[0] = c[0][mvn_pkg::MAG_W-1:0];
      n_in[1] = c[1][mvn_pkg::MAG_W-1:0];
      n_in[2] = c[2][mvn_pkg::MAG_W-1:0];
    end
  end

  // Sequencer for one item at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      norm_valid <= 1'b0;
    end else begin
      norm_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (item_valid) begin
            unique case (item.kind)
              mvn_pkg::KIND_STORE: state <= B_STORE;
              mvn_pkg::KIND_TRI:   state <= B_TRD;
              mvn_pkg::KIND_QUERY: state <= B_QRD;
              default:             state <= B_IDLE;
            endcase
          end
        end
        B_STORE:  state <= B_IDLE;
        B_QRD:    state <= B_QNORM;
        B_QNORM:  state <= B_QWAIT;
        B_QWAIT: begin
          if (n_status.done) begin
            norm_valid <= 1'b1;
            state      <= B_IDLE;
          end
        end
        B_TRD: begin
          if (cnt == 3'd3) begin
            state <= B_EDGE;
          end
        end
        B_EDGE:   state <= B_EMAG;
        B_EMAG:   state <= B_ESHIFT;
        B_ESHIFT: state <= B_CROSS;
        B_CROSS: begin
          if (cnt == 3'd6) begin
            state <= B_CMAG;
          end
        end
        B_CMAG:   state <= B_CSHIFT;
        B_CSHIFT: begin
          if (cmor[mvn_pkg::CROSS_W-1:31] == '0) begin
            state <= B_TNORM;
          end
        end
        B_TNORM:  state <= B_TWAIT;
        B_TWAIT: begin
          if (n_status.done) begin
            state <= n_status.zero ? B_IDLE : B_ARD;
          end
        end
        B_ARD:    state <= B_AWR;
        B_AWR: begin
          state <= (acnt == 2'd2) ? B_IDLE : B_ARD;
        end
        default:  state <= B_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        cur  <= item;
        cnt  <= '0;
        acnt <= '0;
      end
      B_QWAIT: begin
        norm_x <= n_out[0];
        norm_y <= n_out[1];
        norm_z <= n_out[2];
      end
      B_TRD: begin
        cnt <= cnt + 3'd1;
        if (cnt != 3'd0) begin
          vtx[cnt[1:0] - 2'd1] <= v_rdata;
        end
      end
      B_EDGE: begin
        e[0] <= mvn_pkg::EDGE_W'($signed(vtx[1][95:64])) - mvn_pkg::EDGE_W'($signed(vtx[0][95:64]));
        e[1] <= mvn_pkg::EDGE_W'($signed(vtx[1][63:32])) - mvn_pkg::EDGE_W'($signed(vtx[0][63:32]));
        e[2] <= mvn_pkg::EDGE_W'($signed(vtx[1][31:0])) - mvn_pkg::EDGE_W'($signed(vtx[0][31:0]));
        e[3] <= mvn_pkg::EDGE_W'($signed(vtx[2][95:64])) - mvn_pkg::EDGE_W'($signed(vtx[0][95:64]));
        e[4] <= mvn_pkg::EDGE_W'($signed(vtx[2][63:32])) - mvn_pkg::EDGE_W'($signed(vtx[0][63:32]));
        e[5] <= mvn_pkg::EDGE_W'($signed(vtx[2][31:0])) - mvn_pkg::EDGE_W'($signed(vtx[0][31:0]));
      end
      B_EMAG: begin
        emor <= emag(e[0]) | emag(e[1]) | emag(e[2]) | emag(e[3]) | emag(e[4]) | emag(e[5]);
      end
      B_ESHIFT: begin
        for (int i = 0; i < 6; i++) begin
          es[i] <= mvn_pkg::ESH_W'(e[i] >>> eshift);
        end
        cnt <= '0;
      end
      B_CROSS: begin
        // Product of one pair per cycle, folded into its component the cycle after.
        prod <= op_a * op_b;
        cnt  <= cnt + 3'd1;
        unique case (cnt)
          3'd1:    c[0] <= mvn_pkg::CROSS_W'(prod);
          3'd2:    c[0] <= c[0] - mvn_pkg::CROSS_W'(prod);
          3'd3:    c[1] <= mvn_pkg::CROSS_W'(prod);
          3'd4:    c[1] <= c[1] - mvn_pkg::CROSS_W'(prod);
          3'd5:    c[2] <= mvn_pkg::CROSS_W'(prod);
          3'd6:    c[2] <= c[2] - mvn_pkg::CROSS_W'(prod);
          default: begin
          end
        endcase
      end
      B_CMAG: begin
        cmor <= cmag(c[0]) | cmag(c[1]) | cmag(c[2]);
      end
      B_CSHIFT: begin
        // One bit of block shift a cycle until every component is below 2^31.
        if (cmor[mvn_pkg::CROSS_W-1:31] != '0) begin
          cmor <= cmor >> 1;
          c[0] <= c[0] >>> 1;
          c[1] <= c[1] >>> 1;
          c[2] <= c[2] >>> 1;
        end
      end
      B_TWAIT: begin
        face[0] <= n_out[0];
        face[1] <= n_out[1];
        face[2] <= n_out[2];
      end
      B_AWR: begin
        acnt <= acnt + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/mesh_vertex_normals_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Smooth vertex normals for a triangle mesh of up to 1024 vertices. A front queue of two
// items takes a transaction whenever busy is low; a back sequencer works through one item
// at a time. How long a triangle takes also depends on the one-bit-a-cycle block shift of
// its cross product. Most of the time of a query or a triangle goes to the shared normaliser:
// a 32-step integer square root followed by three 48-step restoring divisions on one
// datapath. Each query result appears on norm_x, norm_y and norm_z for exactly one cycle
// with norm_valid high, and must be taken then. Kind 3 is accepted and discarded.
`include "mesh_vertex_normals_core_macros.svh"
module mesh_vertex_normals_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mvn_pkg::KIND_W-1:0]          kind,
  input  logic [mvn_pkg::VIDX_W-1:0]          vertex_index,
  input  logic signed [mvn_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [mvn_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [mvn_pkg::COORD_W-1:0]  pos_z,
  input  logic [mvn_pkg::VIDX_W-1:0]          corner_a,
  input  logic [mvn_pkg::VIDX_W-1:0]          corner_b,
  input  logic [mvn_pkg::VIDX_W-1:0]          corner_c,
  output logic                                norm_valid,
  output logic signed [mvn_pkg::NORM_W-1:0]   norm_x,
  output logic signed [mvn_pkg::NORM_W-1:0]   norm_y,
  output logic signed [mvn_pkg::NORM_W-1:0]   norm_z
);

  mvn_pkg::item_t item;
  logic           item_valid;
  logic           item_pop;
  logic           norm_in_range;

  // Front end: accept and queue transactions.
  mvn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .busy         (busy),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop)
  );

  // Back end: memories, cross product and normalisation.
  mvn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .norm_valid (norm_valid),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z)
  );

  // Every component of a result lies within the unit range.
  assign norm_in_range = (norm_x >= -18'sd65536) && (norm_x <= 18'sd65536) &&
                         (norm_y >= -18'sd65536) && (norm_y <= 18'sd65536) &&
                         (norm_z >= -18'sd65536) && (norm_z <= 18'sd65536);

  // Results never come in adjacent cycles, stay within unit range, and reset leaves all idle.
  `MVN_ASSERT_NEXT(a_strobe_single, clk, rst, norm_valid, !norm_valid)
  `MVN_ASSERT_SAME(a_norm_range, clk, rst, norm_valid, norm_in_range)
  `MVN_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !busy && !norm_valid)

endmodule
`default_nettype wire

// File: tb/sv/tb_mesh_vertex_normals_core.sv
`timescale 1ns / 1ps
module tb_mesh_vertex_normals_core;

  localparam longint SUM_HI = 64'sd33554431;
  localparam longint SUM_LO = -64'sd33554432;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [mvn_pkg::KIND_W-1:0] kind;
  logic [mvn_pkg::VIDX_W-1:0] vertex_index;
  logic signed [mvn_pkg::COORD_W-1:0] pos_x, pos_y, pos_z;
  logic [mvn_pkg::VIDX_W-1:0] corner_a, corner_b, corner_c;
  logic norm_valid;
  logic signed [mvn_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;

  // Shadow copy of the vertex coordinates and the per-vertex normal sums.
  longint vert_pos [mvn_pkg::VERT_DEPTH][3];
  longint vert_sum [mvn_pkg::VERT_DEPTH][3];
  bit vert_written [mvn_pkg::VERT_DEPTH];
  int written_slots [$];

  // Normals still owed by the block, oldest first.
  logic [3*mvn_pkg::NORM_W-1:0] pending_normals [$];
  int mismatches;
  int sender_idle_pct;

  mesh_vertex_normals_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .norm_valid(norm_valid), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit [63:0] magn(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic int shift_needed(input bit [63:0] m, input int bits);
    int s;
    s = 0;
    while ((m >> s) >= (64'd1 << bits)) s++;
    return s;
  endfunction

  function automatic bit [63:0] int_sqrt(input bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector to Q1.16 unit length, rounding half away from zero.
  function automatic bit unit_vector(input longint vx, input longint vy, input longint vz,
                                     output longint nx, output longint ny, output longint nz);
    bit [63:0] len;
    bit [63:0] q [3];
    longint v [3];
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    len = int_sqrt(magn(vx) * magn(vx) + magn(vy) * magn(vy) + magn(vz) * magn(vz));
    nx = 0;
    ny = 0;
    nz = 0;
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) q[i] = (magn(v[i]) * 65536 + len / 2) / len;
    nx = (vx < 0) ? -longint'(q[0]) : longint'(q[0]);
    ny = (vy < 0) ? -longint'(q[1]) : longint'(q[1]);
    nz = (vz < 0) ? -longint'(q[2]) : longint'(q[2]);
    return 1'b1;
  endfunction

  // Face normal of one triangle, accumulated with saturation on each corner.
  function automatic void accumulate_face(input int ia, input int ib, input int ic);
    longint e [6];
    longint c [3];
    longint n [3];
    int crn [3];
    bit [63:0] m;
    int s;
    crn[0] = ia;
    crn[1] = ib;
    crn[2] = ic;
    for (int i = 0; i < 3; i++) begin
      e[i] = vert_pos[ib][i] - vert_pos[ia][i];
      e[3+i] = vert_pos[ic][i] - vert_pos[ia][i];
    end
    m = 0;
    for (int i = 0; i < 6; i++) if (magn(e[i]) > m) m = magn(e[i]);
    s = shift_needed(m, 30);
    for (int i = 0; i < 6; i++) e[i] = e[i] >>> s;
    c[0] = e[1] * e[5] - e[2] * e[4];
    c[1] = e[2] * e[3] - e[0] * e[5];
    c[2] = e[0] * e[4] - e[1] * e[3];
    m = 0;
    for (int i = 0; i < 3; i++) if (magn(c[i]) > m) m = magn(c[i]);
    s = shift_needed(m, 31);
    for (int i = 0; i < 3; i++) c[i] = c[i] >>> s;
    if (!unit_vector(c[0], c[1], c[2], n[0], n[1], n[2])) return;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        vert_sum[crn[k]][i] = vert_sum[crn[k]][i] + n[i];
        if (vert_sum[crn[k]][i] > SUM_HI) vert_sum[crn[k]][i] = SUM_HI;
        if (vert_sum[crn[k]][i] < SUM_LO) vert_sum[crn[k]][i] = SUM_LO;
      end
    end
  endfunction

  // Sends one transaction and updates the shadow state once it is taken.
  task automatic send_item(input logic [mvn_pkg::KIND_W-1:0] k, input int idx,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input int ca, input int cb, input int cc);
    longint nx, ny, nz;
    bit nonzero;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    vertex_index <= idx[mvn_pkg::VIDX_W-1:0];
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    corner_a <= ca[mvn_pkg::VIDX_W-1:0];
    corner_b <= cb[mvn_pkg::VIDX_W-1:0];
    corner_c <= cc[mvn_pkg::VIDX_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    case (k)
      mvn_pkg::KIND_STORE: begin
        vert_pos[idx][0] = longint'(signed'(px));
        vert_pos[idx][1] = longint'(signed'(py));
        vert_pos[idx][2] = longint'(signed'(pz));
        for (int i = 0; i < 3; i++) vert_sum[idx][i] = 0;
        if (!vert_written[idx]) written_slots.push_back(idx);
        vert_written[idx] = 1'b1;
      end
      mvn_pkg::KIND_TRI: accumulate_face(ca, cb, cc);
      mvn_pkg::KIND_QUERY: begin
        nonzero = unit_vector(vert_sum[idx][0], vert_sum[idx][1], vert_sum[idx][2],
                              nx, ny, nz);
        pending_normals.push_back({nx[mvn_pkg::NORM_W-1:0], ny[mvn_pkg::NORM_W-1:0],
                                   nz[mvn_pkg::NORM_W-1:0]});
      end
      default: ;
    endcase
  endtask

  task automatic release_start();
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    release_start();
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  // Each strobed result is checked against the oldest owed normal.
  always @(posedge clk) begin
    logic [3*mvn_pkg::NORM_W-1:0] want;
    if (!rst && norm_valid) begin
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: %0d %0d %0d", norm_x, norm_y, norm_z);
      end else begin
        want = pending_normals.pop_front();
        if (want != {norm_x, norm_y, norm_z}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Normal mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     $signed(want[3*mvn_pkg::NORM_W-1:2*mvn_pkg::NORM_W]),
                     $signed(want[2*mvn_pkg::NORM_W-1:mvn_pkg::NORM_W]),
                     $signed(want[mvn_pkg::NORM_W-1:0]), norm_x, norm_y, norm_z);
        end
      end
    end
  end

  // Extreme coordinates, degenerate and collinear triangles, zero sums, kind 3.
  task automatic test_directed();
    send_item(mvn_pkg::KIND_STORE, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              1023, 1023, 1023);
    send_item(mvn_pkg::KIND_STORE, 1023, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0);
    send_item(mvn_pkg::KIND_QUERY, 1023, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              1023, 1023, 1023);
    send_item(mvn_pkg::KIND_TRI, 0, 32'h0, 32'h0, 32'h0, 0, 1, 1023);
    send_item(mvn_pkg::KIND_QUERY, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_QUERY, 1, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_QUERY, 1023, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 5, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 6, 32'h00020000, 32'h00040000, 32'h00060000, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 7, 32'hfffe0000, 32'hfffc0000, 32'hfffa0000, 0, 0, 0);
    // Collinear corners and a repeated corner add nothing.
    send_item(mvn_pkg::KIND_TRI, 0, 32'h0, 32'h0, 32'h0, 5, 6, 7);
    send_item(mvn_pkg::KIND_TRI, 0, 32'h0, 32'h0, 32'h0, 5, 5, 6);
    send_item(mvn_pkg::KIND_QUERY, 5, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_RSVD, 5, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 5, 6, 7);
    // A tiny right triangle with legs of one LSB.
    send_item(mvn_pkg::KIND_STORE, 8, 32'h1, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 9, 32'h0, 32'h0, 32'h1, 0, 0, 0);
    send_item(mvn_pkg::KIND_TRI, 0, 32'h0, 32'h0, 32'h0, 0, 8, 9);
    send_item(mvn_pkg::KIND_QUERY, 8, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_QUERY, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    // Re-storing a vertex clears its sum.
    send_item(mvn_pkg::KIND_STORE, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_QUERY, 0, 32'h0, 32'h0, 32'h0, 0, 0, 0);
  endtask

  // Drives one normal component past the saturation limit of the sums.
  task automatic test_saturation();
    send_item(mvn_pkg::KIND_STORE, 10, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 11, 32'h0, 32'h0, 32'h00010000, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 12, 32'h0, 32'h00010000, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_STORE, 13, 32'h00010000, 32'h0, 32'h0, 0, 0, 0);
    for (int i = 0; i < 520; i++)
      send_item(mvn_pkg::KIND_TRI, 0, 32'h0, 32'h0, 32'h0, 10, 11, 12);
    for (int i = 0; i < 20; i++)
      send_item(mvn_pkg::KIND_TRI, 0, 32'h0, 32'h0, 32'h0, 10, 13, 12);
    send_item(mvn_pkg::KIND_QUERY, 10, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    send_item(mvn_pkg::KIND_QUERY, 11, 32'h0, 32'h0, 32'h0, 0, 0, 0);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(15)
                                  : 32'h80000000 + $urandom_range(15);
      default: return 32'($signed($urandom_range(1024)) - 512) << 16;
    endcase
  endfunction

  function automatic int pick_written();
    return written_slots[$urandom_range(written_slots.size() - 1)];
  endfunction

  // Mostly stores, triangles on stored corners and queries, some kind 3.
  task automatic test_random(input int count);
    int roll, a, b, c;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 28) begin
        send_item(mvn_pkg::KIND_STORE, $urandom_range(1023), random_coord(), random_coord(),
                  random_coord(), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
      end else if (roll < 73) begin
        a = pick_written();
        b = pick_written();
        c = ($urandom_range(9) == 0) ? a : pick_written();
        send_item(mvn_pkg::KIND_TRI, $urandom_range(1023), $urandom(), $urandom(),
                  $urandom(), a, b, c);
      end else if (roll < 95) begin
        send_item(mvn_pkg::KIND_QUERY, pick_written(), $urandom(), $urandom(), $urandom(),
                  $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end else begin
        send_item(mvn_pkg::KIND_RSVD, $urandom_range(1023), $urandom(), $urandom(),
                  $urandom(), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
      end
    end
  endtask

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mismatches = 0;
    sender_idle_pct = 37;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= mvn_pkg::KIND_STORE;
    vertex_index <= '0;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    corner_a <= '0;
    corner_b <= '0;
    corner_c <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_saturation();
    test_random(150);
    sender_idle_pct = 66;
    test_random(150);
    sender_idle_pct = 0;
    test_random(150);
    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_normals.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
